// File: sv/tmi_pkg.sv
`timescale 1ns / 1ps

package tmi_pkg;

    // Sizes of the program and tape stores
    localparam int PROG_DEPTH = 4096;
    localparam int TAPE_DEPTH = 32768;
    localparam int PROG_AW    = $clog2(PROG_DEPTH);
    localparam int LEN_W      = $clog2(PROG_DEPTH + 1);
    localparam int TAPE_AW    = $clog2(TAPE_DEPTH);

    // Item actions
    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_STEP  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Stored command codes
    localparam logic [2:0] OP_RIGHT = 3'd0;
    localparam logic [2:0] OP_LEFT  = 3'd1;
    localparam logic [2:0] OP_INC   = 3'd2;
    localparam logic [2:0] OP_DEC   = 3'd3;
    localparam logic [2:0] OP_OUT   = 3'd4;
    localparam logic [2:0] OP_IN    = 3'd5;
    localparam logic [2:0] OP_OPEN  = 3'd6;
    localparam logic [2:0] OP_CLOSE = 3'd7;

    // Program characters
    localparam logic [7:0] CH_RIGHT = 8'h3E;  // '>'
    localparam logic [7:0] CH_LEFT  = 8'h3C;  // '<'
    localparam logic [7:0] CH_INC   = 8'h2B;  // '+'
    localparam logic [7:0] CH_DEC   = 8'h2D;  // '-'
    localparam logic [7:0] CH_OUT   = 8'h2E;  // '.'
    localparam logic [7:0] CH_IN    = 8'h2C;  // ','
    localparam logic [7:0] CH_OPEN  = 8'h5B;  // '['
    localparam logic [7:0] CH_CLOSE = 8'h5D;  // ']'

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       input_used;
        logic       halted;
        logic       program_full;
    } t_out_item;

    // Access requests to the program, jump and bracket stores
    typedef struct packed {
        logic               rd_en;
        logic [PROG_AW-1:0] rd_addr;
        logic [PROG_AW-1:0] stk_rd_addr;
        logic               code_we;
        logic [PROG_AW-1:0] code_waddr;
        logic [2:0]         code_wdata;
        logic               tgt_we;
        logic [PROG_AW-1:0] tgt_waddr;
        logic [PROG_AW-1:0] tgt_wdata;
        logic               stk_we;
        logic [PROG_AW-1:0] stk_waddr;
        logic [PROG_AW-1:0] stk_wdata;
    } t_prog_req;

    typedef struct packed {
        logic [2:0]         code;
        logic [PROG_AW-1:0] tgt;
        logic [PROG_AW-1:0] stk;
    } t_prog_rsp;

    // Map a raw character to {is_command, code}
    function automatic logic [3:0] decode_cmd(input logic [7:0] ch);
        logic [3:0] res;
        res = '0;
        unique case (ch)
            CH_RIGHT: res = {1'b1, OP_RIGHT};
            CH_LEFT:  res = {1'b1, OP_LEFT};
            CH_INC:   res = {1'b1, OP_INC};
            CH_DEC:   res = {1'b1, OP_DEC};
            CH_OUT:   res = {1'b1, OP_OUT};
            CH_IN:    res = {1'b1, OP_IN};
            CH_OPEN:  res = {1'b1, OP_OPEN};
            CH_CLOSE: res = {1'b1, OP_CLOSE};
            default:  res = '0;
        endcase
        return res;
    endfunction

endpackage

// File: sv/tmi_program_mem.sv
`timescale 1ns / 1ps

module tmi_program_mem (
    input  logic               i_clk,
    input  tmi_pkg::t_prog_req i_req,
    output tmi_pkg::t_prog_rsp o_rsp
);
    import tmi_pkg::*;

    logic [2:0]         code_mem [PROG_DEPTH];
    logic [PROG_AW-1:0] tgt_mem  [PROG_DEPTH];
    logic [PROG_AW-1:0] stk_mem  [PROG_DEPTH];

    logic [2:0]         r_code_q;
    logic [PROG_AW-1:0] r_tgt_q;
    logic [PROG_AW-1:0] r_stk_q;

    // Command codes
    always_ff @(posedge i_clk) begin
        if (i_req.code_we) begin
            code_mem[i_req.code_waddr] <= i_req.code_wdata;
        end
        if (i_req.rd_en) begin
            r_code_q <= code_mem[i_req.rd_addr];
        end
    end

    // Bracket partners
    always_ff @(posedge i_clk) begin
        if (i_req.tgt_we) begin
            tgt_mem[i_req.tgt_waddr] <= i_req.tgt_wdata;
        end
        if (i_req.rd_en) begin
            r_tgt_q <= tgt_mem[i_req.rd_addr];
        end
    end

    // Open-bracket stack; top entry read on every accepted item
    always_ff @(posedge i_clk) begin
        if (i_req.stk_we) begin
            stk_mem[i_req.stk_waddr] <= i_req.stk_wdata;
        end
        if (i_req.rd_en) begin
            r_stk_q <= stk_mem[i_req.stk_rd_addr];
        end
    end

    assign o_rsp.code = r_code_q;
    assign o_rsp.tgt  = r_tgt_q;
    assign o_rsp.stk  = r_stk_q;

endmodule

// File: sv/tmi_tape_mem.sv
`timescale 1ns / 1ps

module tmi_tape_mem (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_clr_start,
    output logic                        o_clr_busy,
    input  logic                        i_rd_en,
    input  logic [tmi_pkg::TAPE_AW-1:0] i_rd_addr,
    output logic [7:0]                  o_rd_data,
    input  logic                        i_wr_en,
    input  logic [tmi_pkg::TAPE_AW-1:0] i_wr_addr,
    input  logic [7:0]                  i_wr_data
);
    import tmi_pkg::*;

    logic [7:0]         tape_mem [TAPE_DEPTH];
    logic [7:0]         r_rd_q;
    logic               r_clr_active;
    logic [TAPE_AW-1:0] r_clr_addr;

    logic               wr_en;
    logic [TAPE_AW-1:0] wr_addr;
    logic [7:0]         wr_data;

    // Clearing sweep, one cell a cycle; starts itself out of reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            if (r_clr_addr == TAPE_AW'(TAPE_DEPTH - 1)) begin
                r_clr_active <= 1'b0;
                r_clr_addr   <= '0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end else if (i_clr_start) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end
    end

    // Sweep owns the write port while active
    always_comb begin
        wr_en   = r_clr_active | i_wr_en;
        wr_addr = r_clr_active ? r_clr_addr : i_wr_addr;
        wr_data = r_clr_active ? 8'h00 : i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            tape_mem[wr_addr] <= wr_data;
        end
        if (i_rd_en) begin
            r_rd_q <= tape_mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_q;
    assign o_clr_busy = r_clr_active;

endmodule

// File: sv/tape_machine_interpreter.sv
`timescale 1ns / 1ps

// Eight-command tape machine interpreter.
// Input channel: drive i_item with start high; the item is taken at a rising
// edge where start is high and busy is low. Actions: load a program byte,
// execute one instruction, clear the machine.
// Result channel: every item yields exactly one result on o_result, shown
// for one cycle with o_strobe high. The receiver cannot stall; a result
// must be captured in that cycle.
// Step and most loads: the accept reads program, jump and tape memories, the
// S_EXEC state modifies and writes back, and the result is registered; a ']'
// that closes a bracket also passes the S_LINK and S_LINK2 states, since both
// jump-table entries go through the single jump-table write port. A new
// item can be accepted in the cycle its predecessor's result is shown.
// A clear item sweeps the tape memory one cell a cycle. After reset the
// same sweep runs with busy high and no result. Program, jump and stack
// stores are not cleared; only the length, stack-depth, program-counter
// and data-pointer registers are.
module tape_machine_interpreter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  tmi_pkg::t_in_item  i_item,
    output logic               busy,
    output logic               o_strobe,
    output tmi_pkg::t_out_item o_result
);
    import tmi_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_LINK  = 3'd2;
    localparam logic [2:0] S_LINK2 = 3'd3;
    localparam logic [2:0] S_WCLR  = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [1:0]         r_act, n_act;
    logic [7:0]         r_byte, n_byte;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [LEN_W-1:0]   r_depth, n_depth;
    logic [LEN_W-1:0]   r_pc, n_pc;
    logic [TAPE_AW-1:0] r_dp, n_dp;
    logic [PROG_AW-1:0] r_open, n_open;
    logic               r_strobe, n_strobe;
    t_out_item          r_result, n_result;

    t_prog_req          prog_req;
    t_prog_rsp          prog_rsp;
    logic               tape_rd_en;
    logic [TAPE_AW-1:0] tape_rd_addr;
    logic [7:0]         tape_rd_data;
    logic               tape_wr_en;
    logic [7:0]         tape_wr_data;
    logic               clr_start;
    logic               clr_busy;

    logic               accept;
    logic               emit;
    logic [3:0]         dec;
    logic [LEN_W-1:0]   depth_m1;
    logic [LEN_W-1:0]   jump_next;

    tmi_program_mem u_prog (
        .i_clk (i_clk),
        .i_req (prog_req),
        .o_rsp (prog_rsp)
    );

    tmi_tape_mem u_tape (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clr_start (clr_start),
        .o_clr_busy  (clr_busy),
        .i_rd_en     (tape_rd_en),
        .i_rd_addr   (tape_rd_addr),
        .o_rd_data   (tape_rd_data),
        .i_wr_en     (tape_wr_en),
        .i_wr_addr   (r_dp),
        .i_wr_data   (tape_wr_data)
    );

    assign busy   = (r_state != S_IDLE) || clr_busy;
    assign accept = start && !busy;

    assign dec       = decode_cmd(r_byte);
    assign depth_m1  = r_depth - 1'b1;
    assign jump_next = {1'b0, prog_rsp.tgt} + 1'b1;

    // Sequencer: read on accept, modify and write back in the next state(s)
    always_comb begin
        n_state  = r_state;
        n_act    = r_act;
        n_byte   = r_byte;
        n_len    = r_len;
        n_depth  = r_depth;
        n_pc     = r_pc;
        n_dp     = r_dp;
        n_open   = r_open;
        n_strobe = 1'b0;
        n_result = '0;
        emit     = 1'b0;

        prog_req     = '0;
        tape_rd_en   = 1'b0;
        tape_rd_addr = r_dp;
        tape_wr_en   = 1'b0;
        tape_wr_data = tape_rd_data;
        clr_start    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_act                = i_item.action;
                    n_byte               = i_item.data_byte;
                    prog_req.rd_en       = 1'b1;
                    prog_req.rd_addr     = r_pc[PROG_AW-1:0];
                    prog_req.stk_rd_addr = depth_m1[PROG_AW-1:0];
                    tape_rd_en           = 1'b1;
                    n_state              = S_EXEC;
                end
            end

            S_EXEC: begin
                unique case (r_act)
                    ACT_LOAD: begin
                        if (!dec[3]) begin
                            emit = 1'b1;
                        end else if (r_len >= LEN_W'(PROG_DEPTH)) begin
                            n_result.program_full = 1'b1;
                            emit                  = 1'b1;
                        end else begin
                            prog_req.code_we    = 1'b1;
                            prog_req.code_waddr = r_len[PROG_AW-1:0];
                            prog_req.code_wdata = dec[2:0];
                            prog_req.tgt_we     = 1'b1;
                            prog_req.tgt_waddr  = r_len[PROG_AW-1:0];
                            prog_req.tgt_wdata  = '0;
                            if (dec[2:0] == OP_CLOSE && r_depth != '0) begin
                                // pop partner, link both entries next
                                n_depth = depth_m1;
                                n_open  = prog_rsp.stk;
                                n_state = S_LINK;
                            end else begin
                                if (dec[2:0] == OP_OPEN &&
                                    r_depth < LEN_W'(PROG_DEPTH)) begin
                                    prog_req.stk_we    = 1'b1;
                                    prog_req.stk_waddr = r_depth[PROG_AW-1:0];
                                    prog_req.stk_wdata = r_len[PROG_AW-1:0];
                                    n_depth            = r_depth + 1'b1;
                                end
                                n_len = r_len + 1'b1;
                                emit  = 1'b1;
                            end
                        end
                    end

                    ACT_STEP: begin
                        if (r_pc < r_len) begin
                            n_pc = r_pc + 1'b1;
                            unique case (prog_rsp.code)
                                OP_RIGHT: begin
                                    n_dp = (r_dp == TAPE_AW'(TAPE_DEPTH - 1)) ?
                                           '0 : r_dp + 1'b1;
                                end
                                OP_LEFT: begin
                                    n_dp = (r_dp == '0) ?
                                           TAPE_AW'(TAPE_DEPTH - 1) : r_dp - 1'b1;
                                end
                                OP_INC: begin
                                    tape_wr_en   = 1'b1;
                                    tape_wr_data = tape_rd_data + 8'd1;
                                end
                                OP_DEC: begin
                                    tape_wr_en   = 1'b1;
                                    tape_wr_data = tape_rd_data - 8'd1;
                                end
                                OP_OUT: begin
                                    n_result.out_byte  = tape_rd_data;
                                    n_result.out_valid = 1'b1;
                                end
                                OP_IN: begin
                                    tape_wr_en          = 1'b1;
                                    tape_wr_data        = r_byte;
                                    n_result.input_used = 1'b1;
                                end
                                OP_OPEN: begin
                                    if (tape_rd_data == 8'd0) begin
                                        n_pc = jump_next;
                                    end
                                end
                                OP_CLOSE: begin
                                    if (tape_rd_data != 8'd0) begin
                                        n_pc = jump_next;
                                    end
                                end
                                default: begin
                                    n_pc = r_pc + 1'b1;
                                end
                            endcase
                        end
                        emit = 1'b1;
                    end

                    ACT_CLEAR: begin
                        n_len     = '0;
                        n_depth   = '0;
                        n_pc      = '0;
                        n_dp      = '0;
                        clr_start = 1'b1;
                        n_state   = S_WCLR;
                    end

                    default: begin
                        // undefined action: no state change
                        emit = 1'b1;
                    end
                endcase
            end

            // Closing bracket points at its partner
            S_LINK: begin
                prog_req.tgt_we    = 1'b1;
                prog_req.tgt_waddr = r_len[PROG_AW-1:0];
                prog_req.tgt_wdata = r_open;
                n_state            = S_LINK2;
            end

            // Opening bracket points at the closing one
            S_LINK2: begin
                prog_req.tgt_we    = 1'b1;
                prog_req.tgt_waddr = r_open;
                prog_req.tgt_wdata = r_len[PROG_AW-1:0];
                n_len              = r_len + 1'b1;
                emit               = 1'b1;
            end

            S_WCLR: begin
                if (!clr_busy) begin
                    emit = 1'b1;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Result goes out with the state update that finishes the item
        if (emit) begin
            n_state         = S_IDLE;
            n_strobe        = 1'b1;
            n_result.halted = (n_pc >= n_len);
        end
    end

    // Control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= '0;
            r_depth  <= '0;
            r_pc     <= '0;
            r_dp     <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_depth  <= n_depth;
            r_pc     <= n_pc;
            r_dp     <= n_dp;
            r_strobe <= n_strobe;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_act    <= n_act;
        r_byte   <= n_byte;
        r_open   <= n_open;
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

`ifndef ASSERT_OFF
    // A result only follows a cycle of item processing
    a_strobe_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state != S_IDLE))
        else $error("result strobe without a pending item");

    // The cycle after an accept never shows a result
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_strobe)
        else $error("result shown one cycle after accept");

    // Open brackets never outnumber stored commands
    a_depth_le_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_depth <= r_len) && (r_len <= LEN_W'(PROG_DEPTH)))
        else $error("bracket stack deeper than program");

    // A result never reports both an output and an input
    a_out_in_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_result.out_valid && o_result.input_used))
        else $error("output and input reported together");
`endif

endmodule
